// ===== sv/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package plc_pkg;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_DUMP   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_BADPOS = 2'd1,
    STS_FULL   = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic del;
    logic rot;
  } cell_cmd_t;

endpackage

// ===== sv/plc_cell.sv =====
// ----------------------------------------------------------------------------
// plc_cell
// One list slot: holds an entry and takes the new value or a neighbor's
// entry depending on the broadcast command and its own index.
// ----------------------------------------------------------------------------
module plc_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5,
  parameter int VB  = 32
) (
  input  logic               clk,
  input  plc_pkg::cell_cmd_t cmd,
  input  logic [CW-1:0]      pos0,
  input  logic [CW-1:0]      cnt,
  input  logic [VB-1:0]      new_val,
  input  logic [VB-1:0]      left_val,
  input  logic [VB-1:0]      right_val,
  input  logic [VB-1:0]      head_val,
  output logic [VB-1:0]      q
);

  localparam logic [CW:0] IDX_C = (CW+1)'(IDX);

  logic [VB-1:0] q_r;
  logic [VB-1:0] q_nxt;
  logic [CW:0]   pos_x;
  logic [CW:0]   cnt_x;
  logic [CW:0]   idx_p1;

  assign pos_x  = {1'b0, pos0};
  assign cnt_x  = {1'b0, cnt};
  assign idx_p1 = IDX_C + (CW+1)'(1);

  always_comb begin
    q_nxt = q_r;
    if (cmd.ins) begin
      if (IDX_C == pos_x) begin
        q_nxt = new_val;
      end else if (IDX_C > pos_x && IDX_C <= cnt_x) begin
        q_nxt = left_val;
      end
    end else if (cmd.del) begin
      if (IDX_C >= pos_x && idx_p1 < cnt_x) begin
        q_nxt = right_val;
      end
    end else if (cmd.rot) begin
      // rotate the occupied part of the chain toward the head
      if (idx_p1 < cnt_x) begin
        q_nxt = right_val;
      end else if (idx_p1 == cnt_x) begin
        q_nxt = head_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ===== sv/positional_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Bounded ordered list with insert and delete at a 1-based position and a
// dump of all entries, built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage: drive in_func, in_position and in_value with start high; a transfer
// happens at a rising edge where start is high and busy is low.
// Insert and delete update every cell in the cycle of the transfer and give
// one result on the out_ ports in the next cycle, marked by out_strobe; a new
// command may follow in the very next cycle, so these run at one per cycle.
// A dump of n entries rotates the chain toward the head once per cycle and
// emits the head cell each time: busy is high while the dump state runs,
// each result is registered and appears in the cycle after its rotation,
// and the final rotation leaves the list in its original order.
// An empty dump gives one result in the cycle after the transfer and never
// raises busy.
// Every result carries the entry count after the operation; out_last marks
// the final result of a command. Results are shown for one cycle only and
// the receiver cannot stall them.
// Reset (rst_n low, synchronous) empties the list and returns to idle; the
// cell contents are not cleared since only occupied cells are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [4:0]  out_entry_count,
  output logic [31:0] out_entry_value,
  output logic        out_entry_valid,
  output logic        out_last
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = ((CW > 5) ? CW : 5) + 1;
  localparam int XW  = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int CXW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  plc_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  plc_pkg::cell_cmd_t cmd;
  logic [CW-1:0]      pos0;

  logic               strobe_r, strobe_nxt;
  plc_pkg::status_t   status_r, status_nxt;
  logic [CW-1:0]      ocnt_r, ocnt_nxt;
  logic [VALUE_BITS-1:0] oval_r, oval_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic               olast_r, olast_nxt;

  logic               accept;
  logic [PW-1:0]      pos_x;
  logic [PW-1:0]      cnt_x;
  logic               ins_ok;
  logic               del_ok;
  logic               full;
  logic               dump_end;
  logic [XW-1:0]      in_val_x;
  logic [VALUE_BITS-1:0] new_val;
  logic [VALUE_BITS-1:0] q [CAPACITY];

  assign accept   = start && (state_r == plc_pkg::ST_IDLE);
  assign pos_x    = PW'(in_position);
  assign cnt_x    = PW'(count_r);
  assign ins_ok   = (pos_x != '0) && (pos_x <= cnt_x + PW'(1));
  assign del_ok   = (pos_x != '0) && (pos_x <= cnt_x);
  assign full     = (count_r == CAP_C);
  assign pos0     = CW'(pos_x - PW'(1));
  assign dump_end = (k_r == count_r - CW'(1));
  assign in_val_x = XW'(in_value);
  assign new_val  = in_val_x[VALUE_BITS-1:0];

  // chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v;
    logic [VALUE_BITS-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_lastc
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = q[g+1];
    end
    plc_cell #(
      .IDX (g),
      .CW  (CW),
      .VB  (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos0      (pos0),
      .cnt       (count_r),
      .new_val   (new_val),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (q[0]),
      .q         (q[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plc_pkg::ST_IDLE: begin
        if (accept && in_func == plc_pkg::FN_DUMP && count_r != '0) begin
          state_nxt = plc_pkg::ST_DUMP;
        end
      end
      plc_pkg::ST_DUMP: begin
        if (dump_end) begin
          state_nxt = plc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = plc_pkg::ST_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    cmd        = '0;
    count_nxt  = count_r;
    k_nxt      = k_r;
    strobe_nxt = 1'b0;
    status_nxt = plc_pkg::STS_OK;
    ocnt_nxt   = count_r;
    oval_nxt   = '0;
    ovalid_nxt = 1'b0;
    olast_nxt  = 1'b1;
    unique case (state_r)
      plc_pkg::ST_IDLE: begin
        if (accept) begin
          strobe_nxt = 1'b1;
          case (in_func)
            plc_pkg::FN_INSERT: begin
              if (!ins_ok) begin
                status_nxt = plc_pkg::STS_BADPOS;
              end else if (full) begin
                status_nxt = plc_pkg::STS_FULL;
              end else begin
                cmd.ins   = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            plc_pkg::FN_DELETE: begin
              if (!del_ok) begin
                status_nxt = plc_pkg::STS_BADPOS;
              end else begin
                cmd.del   = 1'b1;
                count_nxt = count_r - CW'(1);
              end
            end
            plc_pkg::FN_DUMP: begin
              // a non-empty dump emits from the dump state instead
              if (count_r != '0) begin
                strobe_nxt = 1'b0;
                k_nxt      = '0;
              end
            end
            default: status_nxt = plc_pkg::STS_BADPOS;
          endcase
          ocnt_nxt = count_nxt;
        end
      end
      plc_pkg::ST_DUMP: begin
        cmd.rot    = 1'b1;
        k_nxt      = k_r + CW'(1);
        strobe_nxt = 1'b1;
        oval_nxt   = q[0];
        ovalid_nxt = 1'b1;
        olast_nxt  = dump_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= plc_pkg::ST_IDLE;
      count_r  <= '0;
      k_r      <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      k_r      <= k_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    ocnt_r   <= ocnt_nxt;
    oval_r   <= oval_nxt;
    ovalid_r <= ovalid_nxt;
    olast_r  <= olast_nxt;
  end

  logic [XW-1:0]  oval_x;
  logic [CXW-1:0] ocnt_x;

  assign oval_x = XW'(oval_r);
  assign ocnt_x = CXW'(ocnt_r);

  assign busy            = (state_r == plc_pkg::ST_DUMP);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_entry_count = ocnt_x[4:0];
  assign out_entry_value = oval_x[31:0];
  assign out_entry_valid = ovalid_r;
  assign out_last        = olast_r;

endmodule

// ===== dv/tb_positional_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// tb_positional_list_engine_top
// Self-checking bench for the positional list engine. A shadow list predicts
// the status, count and dumped entries of every command; each strobed result
// is checked against the oldest prediction. Directed corner cases come first,
// then random grow / mixed / shrink phases that fill and drain the list.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_top;

  localparam int LIST_DEPTH = 16;
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int RANDOM_CMDS = 330;

  typedef struct packed {
    plc_pkg::status_t status;
    logic [4:0]       count;
    logic [31:0]      value;
    logic             valid;
    logic             last;
  } list_result_t;

  class list_scoreboard;
    logic [31:0]  cells [LIST_DEPTH];
    int           fill;
    list_result_t pending [$];
    int           errors;
    int           n_cmds;
    int           n_results;
    int           n_full;
    int           n_badpos;

    function new();
      fill = 0;
      errors = 0;
      n_cmds = 0;
      n_results = 0;
      n_full = 0;
      n_badpos = 0;
    endfunction

    function void push_result(plc_pkg::status_t st, logic [31:0] val, logic vld,
                              logic fin);
      list_result_t r;
      r.status = st;
      r.count  = 5'(fill);
      r.value  = val;
      r.valid  = vld;
      r.last   = fin;
      pending.push_back(r);
      if (st == plc_pkg::STS_FULL) n_full++;
      if (st == plc_pkg::STS_BADPOS) n_badpos++;
    endfunction

    // update the shadow list for one accepted command
    function void note_command(logic [1:0] fn, logic [4:0] pos, logic [31:0] val);
      int i;
      n_cmds++;
      if (fn == plc_pkg::FN_INSERT) begin
        if (pos < 1 || int'(pos) > fill + 1) begin
          push_result(plc_pkg::STS_BADPOS, '0, 1'b0, 1'b1);
        end else if (fill >= LIST_DEPTH) begin
          push_result(plc_pkg::STS_FULL, '0, 1'b0, 1'b1);
        end else begin
          for (i = fill; i >= int'(pos); i--) cells[i] = cells[i-1];
          cells[pos-1] = val;
          fill++;
          push_result(plc_pkg::STS_OK, '0, 1'b0, 1'b1);
        end
      end else if (fn == plc_pkg::FN_DELETE) begin
        if (pos < 1 || int'(pos) > fill) begin
          push_result(plc_pkg::STS_BADPOS, '0, 1'b0, 1'b1);
        end else begin
          for (i = pos - 1; i + 1 < fill; i++) cells[i] = cells[i+1];
          fill--;
          push_result(plc_pkg::STS_OK, '0, 1'b0, 1'b1);
        end
      end else if (fn == plc_pkg::FN_DUMP) begin
        if (fill == 0) begin
          push_result(plc_pkg::STS_OK, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < fill; i++)
            push_result(plc_pkg::STS_OK, cells[i], 1'b1, i + 1 == fill);
        end
      end else begin
        push_result(plc_pkg::STS_BADPOS, '0, 1'b0, 1'b1);
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp;
      n_results++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sts=%0d cnt=%0d val=%h vld=%0b last=%0b",
                 $time, got.status, got.count, got.value, got.valid, got.last);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        $display("%0t: mismatch exp sts=%0d cnt=%0d val=%h vld=%0b last=%0b",
                 $time, exp.status, exp.count, exp.value, exp.valid, exp.last);
        $display("%0t:          got sts=%0d cnt=%0d val=%h vld=%0b last=%0b",
                 $time, got.status, got.count, got.value, got.valid, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = plc_pkg::FN_DUMP;
  logic [4:0]  in_position = '0;
  logic [31:0] in_value = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [4:0]  out_entry_count;
  logic [31:0] out_entry_value;
  logic        out_entry_valid;
  logic        out_last;

  list_scoreboard sb = new();

  positional_list_engine_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_entry_value (out_entry_value),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    list_result_t got;
    if (rst_n && out_strobe) begin
      got.status = plc_pkg::status_t'(out_status);
      got.count  = out_entry_count;
      got.value  = out_entry_value;
      got.valid  = out_entry_valid;
      got.last   = out_last;
      sb.check_result(got);
    end
  end

  // present one command and hold it until the transfer happens
  task automatic send_command(logic [1:0] fn, logic [4:0] pos, logic [31:0] val);
    start       <= 1'b1;
    in_func     <= fn;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(fn, pos, val);
  endtask

  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] corner [5] = '{32'h0, 32'h1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
    if ($urandom_range(99) < 15) return corner[$urandom_range(4)];
    return $urandom;
  endfunction

  task automatic random_command(int mode);
    int r;
    int ins_pct;
    r = $urandom_range(99);
    ins_pct = (mode == 0) ? 85 : (mode == 1) ? 50 : 20;
    if (r < 5) begin
      // noise: any code, any position
      send_command(2'($urandom_range(3)), 5'($urandom_range(31)), $urandom);
    end else if (r < 15) begin
      send_command(plc_pkg::FN_DUMP, 5'($urandom_range(31)), $urandom);
    end else if ($urandom_range(99) < ins_pct) begin
      if ($urandom_range(99) < 10)
        send_command(plc_pkg::FN_INSERT, 5'($urandom_range(31)), pick_value());
      else
        send_command(plc_pkg::FN_INSERT, 5'($urandom_range(1, sb.fill + 1)), pick_value());
    end else begin
      if (sb.fill == 0 || $urandom_range(99) < 10)
        send_command(plc_pkg::FN_DELETE, 5'($urandom_range(31)), $urandom);
      else
        send_command(plc_pkg::FN_DELETE, 5'($urandom_range(1, sb.fill)), $urandom);
    end
  endtask

  initial begin
    int n;
    int waited;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corners
    send_command(plc_pkg::FN_DUMP,   5'd0,  32'h0);
    send_command(plc_pkg::FN_DELETE, 5'd1,  32'h0);
    send_command(plc_pkg::FN_DELETE, 5'd0,  32'h0);
    send_command(plc_pkg::FN_INSERT, 5'd0,  32'h1234_5678);
    send_command(plc_pkg::FN_INSERT, 5'd2,  32'h1234_5678);
    // build head, tail and middle
    send_command(plc_pkg::FN_INSERT, 5'd1,  32'h8000_0000);
    send_command(plc_pkg::FN_INSERT, 5'd2,  32'h7fff_ffff);
    send_command(plc_pkg::FN_INSERT, 5'd1,  32'hffff_ffff);
    send_command(plc_pkg::FN_INSERT, 5'd2,  32'h0000_0000);
    send_command(plc_pkg::FN_INSERT, 5'd31, 32'hdead_beef);
    send_command(plc_pkg::FN_DUMP,   5'd31, 32'hffff_ffff);
    send_command(plc_pkg::FN_DELETE, 5'd4,  32'h0);
    send_command(plc_pkg::FN_DELETE, 5'd0,  32'h0);
    send_command(plc_pkg::FN_DELETE, 5'd5,  32'h0);
    send_command(FN_UNUSED,          5'd1,  32'h5555_aaaa);
    send_command(plc_pkg::FN_DELETE, 5'd1,  32'h0);
    send_command(plc_pkg::FN_DUMP,   5'd0,  32'h0);
    send_command(plc_pkg::FN_DELETE, 5'd31, 32'h0);
    send_command(plc_pkg::FN_DELETE, 5'd1,  32'h0);
    send_command(plc_pkg::FN_DELETE, 5'd1,  32'h0);
    send_command(plc_pkg::FN_DUMP,   5'd0,  32'h0);
    maybe_idle(1'b1);

    // phases of 40: grow, mixed, shrink; no gaps in the middle stretch
    for (n = 0; n < RANDOM_CMDS; n++) begin
      random_command((n / 40) % 3);
      maybe_idle(n < 120 || n >= 200);
    end
    start <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors += sb.pending.size();
      $display("%0t: %0d results never arrived", $time, sb.pending.size());
    end

    $display("ran %0d commands, checked %0d results", sb.n_cmds, sb.n_results);
    $display("list-full rejects %0d, bad-position rejects %0d", sb.n_full, sb.n_badpos);
    if (sb.errors == 0)
      $display("tb_positional_list_engine_top OK");
    else
      $display("tb_positional_list_engine_top NOT OK");
    $finish;
  end

  initial begin
    #400000;
    $display("%0t: run timed out", $time);
    $display("tb_positional_list_engine_top NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/plc_pkg.sv
sv/plc_cell.sv
sv/positional_list_engine_top.sv
dv/tb_positional_list_engine_top.sv
